>>> sv/programmable_logic_function_cell_top_macros.svh
// assertion helpers, clocked on clk and held off during rst
`ifndef PROGRAMMABLE_LOGIC_FUNCTION_CELL_TOP_MACROS_SVH
`define PROGRAMMABLE_LOGIC_FUNCTION_CELL_TOP_MACROS_SVH

// consequent checked in the same cycle
`define PLFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define PLFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/plfc_pkg.sv
package plfc_pkg;

  typedef enum logic [3:0] {
    FN_NOT    = 4'd0,
    FN_AND    = 4'd1,
    FN_OR     = 4'd2,
    FN_XOR    = 4'd3,
    FN_BITAND = 4'd4,
    FN_EQ     = 4'd5,
    FN_LESS   = 4'd6,
    FN_MORE   = 4'd7,
    FN_SUB    = 4'd8,
    FN_ADD    = 4'd9,
    FN_HYST   = 4'd10,
    FN_BLINK  = 4'd11,
    FN_PULSE  = 4'd12,
    FN_SR     = 4'd13,
    FN_TOGGLE = 4'd14,
    FN_COUNT  = 4'd15
  } func_t;

  typedef enum logic [2:0] {
    REG_FUNC_TYPE   = 3'd0,
    REG_OPTIONS     = 3'd1,
    REG_EDGE_SELECT = 3'd2,
    REG_COUNT_STEPS = 3'd3,
    REG_COUNT_LOW   = 3'd4,
    REG_COUNT_HIGH  = 3'd5,
    REG_PRESET_ONE  = 3'd6,
    REG_PRESET_TWO  = 3'd7
  } reg_idx_t;

  // option bit positions
  localparam int OPT_INVERT    = 0;
  localparam int OPT_WRAP_HIGH = 1;
  localparam int OPT_WRAP_LOW  = 2;
  localparam int OPT_NIN_LSB   = 3;

  // edge select codes, anything else means any change
  localparam logic [1:0] EDGE_RISE = 2'd0;
  localparam logic [1:0] EDGE_FALL = 2'd1;

  localparam int NUM_INPUTS = 4;
  localparam int STEP_W     = 16;

endpackage

>>> sv/programmable_logic_function_cell_top.sv
// pipeline: input register, then result register; throughput: one input transaction per
//   cycle unless res_stall holds a valid result, the held result and previous inputs
//   feed back through one register stage of evaluation logic
// reset (rst, synchronous, active high): registers back to their defaults,
//   previous inputs and held result cleared, both pipeline stages emptied
// configuration port is always ready, a write takes effect on the next cycle
`include "programmable_logic_function_cell_top_macros.svh"

module programmable_logic_function_cell_top
  import plfc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32)-1:0] cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_a,
  input  logic signed [VALUE_WIDTH-1:0] in_b,
  input  logic signed [VALUE_WIDTH-1:0] in_c,
  input  logic signed [VALUE_WIDTH-1:0] in_d,
  // result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic signed [VALUE_WIDTH-1:0] result_value,
  output logic                          updated
);

  // wide enough for a value plus or minus a step without wrapping
  localparam int ExtW = ((VALUE_WIDTH > STEP_W) ? VALUE_WIDTH : STEP_W) + 2;

  func_t                         func_type;
  logic [4:0]                    options;
  logic [7:0]                    edge_select;
  logic [31:0]                   count_steps;
  logic signed [VALUE_WIDTH-1:0] count_low;
  logic signed [VALUE_WIDTH-1:0] count_high;
  logic signed [VALUE_WIDTH-1:0] preset_one;
  logic signed [VALUE_WIDTH-1:0] preset_two;

  logic                          stage_valid;
  logic signed [VALUE_WIDTH-1:0] stage_in [NUM_INPUTS];
  logic signed [VALUE_WIDTH-1:0] prev_in  [NUM_INPUTS];
  logic signed [VALUE_WIDTH-1:0] held_result;

  logic                          out_move;
  logic                          stage_fire;
  logic [NUM_INPUTS-1:0]         edge_hit;
  logic [NUM_INPUTS-1:0]         nonzero;
  logic                          any_edge;
  logic signed [VALUE_WIDTH-1:0] held_result_next;

  logic signed [ExtW-1:0]        held_ext;
  logic signed [ExtW-1:0]        dec_ext;
  logic signed [ExtW-1:0]        inc_ext;
  logic signed [ExtW-1:0]        down_ext;
  logic signed [ExtW-1:0]        up_ext;
  logic signed [ExtW-1:0]        low_ext;
  logic signed [ExtW-1:0]        high_ext;
  logic                          underflow;
  logic                          overflow;

  function automatic logic signed [VALUE_WIDTH-1:0] show_value(
    input logic signed [VALUE_WIDTH-1:0] v,
    input logic                          inv
  );
    if (inv) begin
      show_value = VALUE_WIDTH'(v == '0);
    end else begin
      show_value = v;
    end
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      func_type   <= FN_NOT;
      options     <= '0;
      edge_select <= '0;
      count_steps <= 32'd65537;
      count_low   <= '0;
      count_high  <= VALUE_WIDTH'(255);
      preset_one  <= '0;
      preset_two  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_FUNC_TYPE:   func_type   <= func_t'(cfg_data[3:0]);
        REG_OPTIONS:     options     <= cfg_data[4:0];
        REG_EDGE_SELECT: edge_select <= cfg_data[7:0];
        REG_COUNT_STEPS: count_steps <= cfg_data[31:0];
        REG_COUNT_LOW:   count_low   <= cfg_data[VALUE_WIDTH-1:0];
        REG_COUNT_HIGH:  count_high  <= cfg_data[VALUE_WIDTH-1:0];
        REG_PRESET_ONE:  preset_one  <= cfg_data[VALUE_WIDTH-1:0];
        REG_PRESET_TWO:  preset_two  <= cfg_data[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign out_move   = !res_valid || !res_stall;
  assign stage_fire = stage_valid && out_move;
  assign in_stall   = stage_valid && !out_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_in[0] <= in_a;
      stage_in[1] <= in_b;
      stage_in[2] <= in_c;
      stage_in[3] <= in_d;
    end
  end

  // edge detection against the previous transaction
  always_comb begin
    for (int i = 0; i < NUM_INPUTS; i++) begin
      nonzero[i] = (stage_in[i] != '0);
      if (stage_in[i] == prev_in[i]) begin
        edge_hit[i] = 1'b0;
      end else if (edge_select[2*i +: 2] == EDGE_RISE) begin
        edge_hit[i] = (prev_in[i] < stage_in[i]);
      end else if (edge_select[2*i +: 2] == EDGE_FALL) begin
        edge_hit[i] = (stage_in[i] < prev_in[i]);
      end else begin
        edge_hit[i] = 1'b1;
      end
    end
    any_edge = |edge_hit;
  end

  // counter limits, compared without wrapping
  always_comb begin
    held_ext  = ExtW'(held_result);
    dec_ext   = $signed(ExtW'(count_steps[31:16]));
    inc_ext   = $signed(ExtW'(count_steps[15:0]));
    low_ext   = ExtW'(count_low);
    high_ext  = ExtW'(count_high);
    down_ext  = held_ext - dec_ext;
    up_ext    = held_ext + inc_ext;
    underflow = (down_ext < low_ext);
    overflow  = (up_ext > high_ext);
  end

  always_comb begin
    logic and_acc;
    logic or_acc;
    and_acc = 1'b1;
    or_acc  = 1'b0;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      if (2'(i) <= options[OPT_NIN_LSB +: 2]) begin
        and_acc = and_acc & nonzero[i];
        or_acc  = or_acc | nonzero[i];
      end
    end

    held_result_next = held_result;
    case (func_type)
      FN_NOT:    held_result_next = VALUE_WIDTH'(!nonzero[0]);
      FN_AND:    held_result_next = VALUE_WIDTH'(and_acc);
      FN_OR:     held_result_next = VALUE_WIDTH'(or_acc);
      FN_XOR:    held_result_next = VALUE_WIDTH'(nonzero[0] ^ nonzero[1]);
      FN_BITAND: held_result_next = stage_in[0] & stage_in[1];
      FN_EQ:     held_result_next = VALUE_WIDTH'(stage_in[0] == stage_in[1]);
      FN_LESS:   held_result_next = VALUE_WIDTH'(stage_in[0] < stage_in[1]);
      FN_MORE:   held_result_next = VALUE_WIDTH'(stage_in[0] > stage_in[1]);
      FN_SUB:    held_result_next = stage_in[0] - stage_in[1];
      FN_ADD:    held_result_next = stage_in[0] + stage_in[1];
      FN_HYST: begin
        if (stage_in[0] < stage_in[1]) begin
          held_result_next = '0;
        end else if (stage_in[0] > stage_in[2]) begin
          held_result_next = VALUE_WIDTH'(1);
        end
      end
      FN_BLINK:  held_result_next = stage_in[0];
      FN_PULSE: begin
        if (edge_hit[1]) begin
          held_result_next = '0;
        end else if (edge_hit[0]) begin
          held_result_next = VALUE_WIDTH'(1);
        end
      end
      FN_SR: begin
        if (edge_hit[0]) begin
          held_result_next = '0;
        end else if (edge_hit[1]) begin
          held_result_next = VALUE_WIDTH'(1);
        end
      end
      FN_TOGGLE: begin
        if (edge_hit[1]) begin
          held_result_next = '0;
        end else if (edge_hit[2]) begin
          held_result_next = VALUE_WIDTH'(1);
        end else if (edge_hit[0]) begin
          held_result_next = VALUE_WIDTH'(held_result == '0);
        end
      end
      FN_COUNT: begin
        if (edge_hit[2]) begin
          held_result_next = preset_one;
        end else if (edge_hit[3]) begin
          held_result_next = preset_two;
        end else if (edge_hit[0]) begin
          if (underflow) begin
            held_result_next = options[OPT_WRAP_LOW] ? preset_one : count_low;
          end else begin
            held_result_next = down_ext[VALUE_WIDTH-1:0];
          end
        end else if (edge_hit[1]) begin
          if (overflow) begin
            held_result_next = options[OPT_WRAP_HIGH] ? preset_two : count_high;
          end else begin
            held_result_next = up_ext[VALUE_WIDTH-1:0];
          end
        end
      end
      default: held_result_next = held_result;
    endcase
  end

  // cell state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_result <= '0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
        prev_in[i] <= '0;
      end
    end else if (stage_fire) begin
      if (any_edge) begin
        held_result <= held_result_next;
      end
      for (int i = 0; i < NUM_INPUTS; i++) begin
        prev_in[i] <= stage_in[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_move) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      result_value <= show_value(any_edge ? held_result_next : held_result,
                                 options[OPT_INVERT]);
      updated      <= any_edge;
    end
  end

  `PLFC_ASSERT_NOW(a_stall_needs_stage, in_stall, stage_valid, "input stalled with empty stage")
  `PLFC_ASSERT_NEXT(a_hold_no_edge, stage_fire && !any_edge, $stable(held_result), "held result changed without an edge")
  `PLFC_ASSERT_NOW(a_result_matches_held, res_valid, result_value == show_value(held_result, options[OPT_INVERT]), "shown result differs from held result")
  `PLFC_ASSERT_NEXT(a_prev_tracks_stage, stage_fire, prev_in[0] == $past(stage_in[0]), "previous input not refreshed")

endmodule
